>>> design/spsq_pkg.sv
// ----------------------------------------------------------------------------
// spsq_pkg
// Shared types and codes for the stable priority sorted queue.
// ----------------------------------------------------------------------------
package spsq_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int PID_W     = 16;
    localparam int BURST_W   = 16;
    localparam int PRIO_W    = 8;
    localparam int STATUS_W  = 2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DRAIN  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_EMIT  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } t_entry;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } t_op;

    // broadcast to every cell
    typedef struct packed {
        t_op    op;
        t_entry entry;
    } t_ctl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   gt;
        t_entry entry;
    } t_link;

endpackage

>>> design/spsq_cell.sv
// ----------------------------------------------------------------------------
// spsq_cell
// One slot of the sorted row. On insert it holds, takes the new word, or takes
// its left neighbor's word; on drain it takes its right neighbor's word.
// ----------------------------------------------------------------------------
module spsq_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spsq_pkg::t_ctl  i_ctl,
    input  spsq_pkg::t_link i_left,
    input  spsq_pkg::t_link i_right,
    output spsq_pkg::t_link o_link
);

    logic             r_valid;
    spsq_pkg::t_entry r_entry;
    logic             n_valid;
    spsq_pkg::t_entry n_entry;
    logic             w_gt;

    // empty slot or strictly larger priority number: new word lands at or before us
    assign w_gt = !r_valid || (r_entry.prio > i_ctl.entry.prio);

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        case (i_ctl.op)
            spsq_pkg::OP_INSERT: begin
                if (w_gt && i_left.gt) begin
                    n_valid = i_left.valid;
                    n_entry = i_left.entry;
                end else if (w_gt) begin
                    n_valid = 1'b1;
                    n_entry = i_ctl.entry;
                end
            end
            spsq_pkg::OP_SHIFT: begin
                n_valid = i_right.valid;
                n_entry = i_right.entry;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

    assign o_link.valid = r_valid;
    assign o_link.gt    = w_gt;
    assign o_link.entry = r_entry;

endmodule

>>> design/stable_priority_sorted_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_sorted_queue
// Priority queue built as a row of DEPTH cells kept sorted by priority, ties in
// arrival order. Insert places a word as the row shifts in parallel; drain streams all words.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       i_valid / o_ready    i_kind i_process_id i_burst_length i_priority_level
//  out      o_valid / i_ready    o_status o_out_process_id o_out_burst_length
//                                o_out_priority_level o_last_of_run
//
//  Insert: one per cycle unless a drain runs or the output is stalled; the
//  row shifts in parallel, no result unless full. Drain of N words: one word
//  per cycle from cell 0 as the row shifts left; input is held off until the
//  last word is loaded into the output register. Output stalls pause the drain.
//  Synchronous reset clears cell valid bits and control; no clearing pass.
// ----------------------------------------------------------------------------
module stable_priority_sorted_queue #(
    parameter int DEPTH = spsq_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic [spsq_pkg::PID_W-1:0]    i_process_id,
    input  logic [spsq_pkg::BURST_W-1:0]  i_burst_length,
    input  logic [spsq_pkg::PRIO_W-1:0]   i_priority_level,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [spsq_pkg::STATUS_W-1:0] o_status,
    output logic [spsq_pkg::PID_W-1:0]    o_out_process_id,
    output logic [spsq_pkg::BURST_W-1:0]  o_out_burst_length,
    output logic [spsq_pkg::PRIO_W-1:0]   o_out_priority_level,
    output logic                          o_last_of_run
);

    spsq_pkg::t_link w_link [DEPTH];
    spsq_pkg::t_link w_none;
    spsq_pkg::t_ctl  w_ctl;
    logic [DEPTH-1:0] w_valid;

    logic r_drain;
    logic r_out_valid;
    logic n_out_valid;
    logic [spsq_pkg::STATUS_W-1:0] r_out_status;
    spsq_pkg::t_entry              r_out_entry;
    logic                          r_out_last;

    logic w_slot_free;
    logic w_in_acc;
    logic w_full;
    logic w_step;

    assign w_none      = '0;
    assign w_slot_free = !r_out_valid || i_ready;
    assign o_ready     = !r_drain && w_slot_free;
    assign w_in_acc    = i_valid && o_ready;
    assign w_full      = w_link[DEPTH-1].valid;
    assign w_step      = r_drain && w_slot_free;

    always_comb begin
        w_ctl.entry.pid   = i_process_id;
        w_ctl.entry.burst = i_burst_length;
        w_ctl.entry.prio  = i_priority_level;
        w_ctl.op          = spsq_pkg::OP_HOLD;
        if (w_in_acc && (i_kind == spsq_pkg::KIND_INSERT) && !w_full) begin
            w_ctl.op = spsq_pkg::OP_INSERT;
        end else if (w_step) begin
            w_ctl.op = spsq_pkg::OP_SHIFT;
        end
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        spsq_pkg::t_link w_left;
        spsq_pkg::t_link w_right;
        if (gi == 0) begin : g_first
            assign w_left = w_none;
        end else begin : g_mid_l
            assign w_left = w_link[gi-1];
        end
        if (gi == DEPTH-1) begin : g_last
            assign w_right = w_none;
        end else begin : g_mid_r
            assign w_right = w_link[gi+1];
        end
        spsq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[gi])
        );
        assign w_valid[gi] = w_link[gi].valid;
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        if (w_in_acc) begin
            if (i_kind == spsq_pkg::KIND_DRAIN) begin
                if (!w_link[0].valid) begin
                    n_out_valid = 1'b1;
                end
            end else if (w_full) begin
                n_out_valid = 1'b1;
            end
        end else if (w_step) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_in_acc) begin
                if ((i_kind == spsq_pkg::KIND_DRAIN) && w_link[0].valid) begin
                    r_drain <= 1'b1;
                end
            end else if (w_step && !w_link[1].valid) begin
                r_drain <= 1'b0;
            end
        end
        if (w_in_acc) begin
            r_out_entry <= '0;
            if (i_kind == spsq_pkg::KIND_DRAIN) begin
                r_out_status <= spsq_pkg::ST_EMPTY;
                r_out_last   <= 1'b1;
            end else begin
                r_out_status <= spsq_pkg::ST_DROP;
                r_out_last   <= 1'b0;
            end
        end else if (w_step) begin
            r_out_entry  <= w_link[0].entry;
            r_out_status <= spsq_pkg::ST_EMIT;
            r_out_last   <= !w_link[1].valid;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_status             = r_out_status;
    assign o_out_process_id     = r_out_entry.pid;
    assign o_out_burst_length   = r_out_entry.burst;
    assign o_out_priority_level = r_out_entry.prio;
    assign o_last_of_run        = r_out_last;

    a_drain_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> w_link[0].valid)
        else $error("drain active with empty head cell");

    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + 1'b1) & w_valid) == '0)
        else $error("cell valid bits not packed from cell 0");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == spsq_pkg::OP_INSERT) |=>
            (w_valid == {$past(w_valid[DEPTH-2:0]), 1'b1}))
        else $error("insert did not add exactly one word");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out_entry)))
        else $error("output word overwritten while stalled");

endmodule

>>> tb/spsq_order_checker.sv
// ----------------------------------------------------------------------------
// spsq_order_checker
// Watches both channels of the sorted queue, keeps its own sorted copy of the
// stored entries and checks every result word, in order and field by field.
// ----------------------------------------------------------------------------
module spsq_order_checker
    import spsq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                o_ready,
    input  logic                i_kind,
    input  logic [PID_W-1:0]    i_process_id,
    input  logic [BURST_W-1:0]  i_burst_length,
    input  logic [PRIO_W-1:0]   i_priority_level,
    input  logic                o_valid,
    input  logic                i_ready,
    input  logic [STATUS_W-1:0] o_status,
    input  logic [PID_W-1:0]    o_out_process_id,
    input  logic [BURST_W-1:0]  o_out_burst_length,
    input  logic [PRIO_W-1:0]   o_out_priority_level,
    input  logic                o_last_of_run,
    output int                  o_fail_count,
    output int                  o_due_count,
    output int                  o_word_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_entry              entry;
        logic                last;
    } t_drain_word;

    t_entry      shadow_q[$];
    t_drain_word due_q[$];
    int          fails;
    int          words_seen;

    initial begin
        fails        = 0;
        words_seen   = 0;
        o_fail_count = 0;
        o_due_count  = 0;
        o_word_count = 0;
    end

    function automatic t_drain_word make_word(logic [STATUS_W-1:0] status, t_entry e,
                                              logic last);
        t_drain_word w;
        w.status = status;
        w.entry  = e;
        w.last   = last;
        return w;
    endfunction

    function automatic int field_miss(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic apply_word(input logic kind, input t_entry e);
        int pos;
        if (kind == KIND_INSERT) begin
            if (shadow_q.size() >= DEPTH) begin
                due_q.push_back(make_word(ST_DROP, '0, 1'b0));
            end else begin
                pos = 0;
                while (pos < shadow_q.size() && shadow_q[pos].prio <= e.prio)
                    pos++;
                shadow_q.insert(pos, e);
            end
        end else if (shadow_q.size() == 0) begin
            due_q.push_back(make_word(ST_EMPTY, '0, 1'b1));
        end else begin
            foreach (shadow_q[i])
                due_q.push_back(make_word(ST_EMIT, shadow_q[i], i == shadow_q.size() - 1));
            shadow_q.delete();
        end
    endtask

    task automatic check_word();
        t_drain_word w;
        words_seen++;
        if (due_q.size() == 0) begin
            $error("result word with nothing due: status 0x%0h", o_status);
            fails++;
        end else begin
            w = due_q.pop_front();
            fails += field_miss("status", 16'(w.status), 16'(o_status));
            fails += field_miss("out_process_id", w.entry.pid, o_out_process_id);
            fails += field_miss("out_burst_length", w.entry.burst, o_out_burst_length);
            fails += field_miss("out_priority_level", 16'(w.entry.prio),
                                16'(o_out_priority_level));
            fails += field_miss("last_of_run", 16'(w.last), 16'(o_last_of_run));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_q.delete();
            due_q.delete();
        end else begin
            if (o_valid && i_ready)
                check_word();
            if (i_valid && o_ready)
                apply_word(i_kind, '{i_process_id, i_burst_length, i_priority_level});
        end
        o_fail_count <= fails;
        o_due_count  <= due_q.size();
        o_word_count <= words_seen;
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the stable priority sorted queue: directed corner cases, a
// fill past capacity under a long output stall, then random insert runs with
// ties and drains, both sides idling at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spsq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES = 2 * DEPTH + 10;
    localparam int WORD_GOAL   = 250;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_kind;
    logic [PID_W-1:0]    i_process_id;
    logic [BURST_W-1:0]  i_burst_length;
    logic [PRIO_W-1:0]   i_priority_level;
    logic                o_valid;
    logic                i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [PID_W-1:0]    o_out_process_id;
    logic [BURST_W-1:0]  o_out_burst_length;
    logic [PRIO_W-1:0]   o_out_priority_level;
    logic                o_last_of_run;

    int fail_count;
    int due_count;
    int result_words;
    int words_sent;
    int drains_sent;
    bit in_fire;
    bit out_fire;
    bit steady;
    bit stall_long;

    stable_priority_sorted_queue #(.DEPTH(DEPTH)) i_dut (.*);

    spsq_order_checker #(.DEPTH(DEPTH)) i_checker (
        .o_fail_count(fail_count),
        .o_due_count (due_count),
        .o_word_count(result_words),
        .*
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        in_fire  <= i_rst_n && i_valid && o_ready;
        out_fire <= i_rst_n && o_valid && i_ready;
    end

    task automatic send_word(input logic kind, input logic [PID_W-1:0] pid,
                             input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_kind           <= kind;
        i_process_id     <= pid;
        i_burst_length   <= burst;
        i_priority_level <= prio;
        do @(negedge i_clk); while (!in_fire);
        words_sent++;
        if (kind == KIND_DRAIN)
            drains_sent++;
    endtask

    task automatic insert_entry(input logic [PRIO_W-1:0] prio);
        send_word(KIND_INSERT, PID_W'($urandom), BURST_W'($urandom), prio);
    endtask

    task automatic drain_all();
        send_word(KIND_DRAIN, PID_W'($urandom), BURST_W'($urandom), PRIO_W'($urandom));
    endtask

    task automatic await_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (due_count != 0)
            @(negedge i_clk);
    endtask

    // one run of inserts closed by a drain; narrow priority spread makes ties likely
    task automatic random_round();
        int                n;
        bit                narrow;
        logic [PRIO_W-1:0] base;
        logic [PRIO_W-1:0] prio;
        steady = ($urandom_range(0, 3) == 0);
        n      = ($urandom_range(0, 9) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 4)
                                             : $urandom_range(0, 8);
        narrow = $urandom_range(0, 1);
        base   = PRIO_W'($urandom);
        repeat (n) begin
            prio = narrow ? base ^ PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
            if ($urandom_range(0, 19) == 0)
                drain_all();
            else
                insert_entry(prio);
        end
        drain_all();
        if ($urandom_range(0, 7) == 0)
            drain_all();
    endtask

    initial begin : receiver
        int gap;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (stall_long) begin
                gap        = HOLD_CYCLES;
                stall_long = 1'b0;
            end else begin
                gap = steady ? 0 : $urandom_range(0, 5);
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(negedge i_clk); while (!out_fire && !stall_long);
        end
    end

    initial begin : stimulus
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_kind           = KIND_INSERT;
        i_process_id     = '0;
        i_burst_length   = '0;
        i_priority_level = '0;
        steady           = 1'b1;
        stall_long       = 1'b0;
        words_sent       = 0;
        drains_sent      = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty drain, field extremes, ties at both ends and in the middle
        drain_all();
        send_word(KIND_INSERT, 16'h0000, 16'h0000, 8'h00);
        send_word(KIND_INSERT, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_word(KIND_INSERT, 16'h0001, 16'h5555, 8'h80);
        send_word(KIND_INSERT, 16'h0002, 16'hAAAA, 8'h80);
        send_word(KIND_INSERT, 16'hFFFF, 16'h0000, 8'h00);
        send_word(KIND_INSERT, 16'h0000, 16'hFFFF, 8'hFF);
        send_word(KIND_INSERT, 16'hAAAA, 16'h5555, 8'h7F);
        drain_all();
        drain_all();
        send_word(KIND_INSERT, 16'h5A5A, 16'hA5A5, 8'h01);
        drain_all();
        steady = 1'b0;

        // fill past capacity while the output is held off
        await_results();
        stall_long = 1'b1;
        repeat (DEPTH + 6)
            insert_entry(PRIO_W'($urandom));
        drain_all();
        await_results();

        while (words_sent < WORD_GOAL)
            random_round();

        await_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Covered %0d input words (%0d drains), with fills past capacity and ties.",
                 words_sent, drains_sent);
        $display("Compared %0d result words in order under random stalls on both sides.",
                 result_words);
        if (fail_count == 0 && due_count == 0) begin
            $display("stable_priority_sorted_queue verification clean");
        end else begin
            $display("stable_priority_sorted_queue verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("stable_priority_sorted_queue verification failed");
        $finish;
    end

endmodule
